// ===== rtl/core/ppt_pkg.sv =====
`default_nettype none

package ppt_pkg;

   localparam int OP_BITS       = 2;
   localparam int DUR_BITS      = 32;
   localparam int CSR_ADDR_BITS = 1;

   typedef enum logic [OP_BITS-1:0] {
      OP_PLAY    = 2'd0,
      OP_PAUSE   = 2'd1,
      OP_RESUME  = 2'd2,
      OP_RESTART = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_DURATION = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PERIODIC = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/ppt_div.sv =====
`default_nettype none

module ppt_div
   import ppt_pkg::*;
#(
   parameter int W  = 32,
   parameter int QB = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [W-1:0]  numerator,
   input  wire logic [W-1:0]  denominator,
   output logic [QB-1:0]      quotient,
   output div_status_type     status
);

   localparam int CNT_W = $clog2(QB + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     den_ff, den_in;
   logic [QB-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   logic [W:0] shifted;
   logic [W:0] den_x;
   logic [W:0] diff;
   logic       ge;

   // one restoring step per cycle
   always_comb begin
      shifted = {rem_ff, 1'b0};
      den_x   = {1'b0, den_ff};
      ge      = shifted >= den_x;
      diff    = shifted - den_x;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = numerator;
         den_in = denominator;
         quo_in = '0;
         cnt_in = CNT_W'(QB);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? diff[W-1:0] : shifted[W-1:0];
         quo_in  = {quo_ff[QB-2:0], ge};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pausable_phase_timer.sv =====
`default_nettype none
// Play: the request is registered, evaluated, divided and loaded into the output register;
//   the restoring divider gives one quotient bit a cycle. Requests are taken only when idle.
// Pause, resume, restart: registered and evaluated, no divide step. The next transaction
//   is taken while a finished result still waits in the output register.
// Synchronous active-high reset: duration 1, one-shot, timer active, not paused,
//   start time zero (not started).

module pausable_phase_timer
   import ppt_pkg::*;
#(
   parameter int TIME_BITS  = 32,
   parameter int PHASE_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // operation, timestamp, zero pad
   input  wire logic [((OP_BITS+TIME_BITS+7)/8)*8-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // phase, phase_valid, is_active, is_paused, zero pad
   output logic [((PHASE_BITS+3+7)/8)*8-1:0] rsp_tdata,
   input  wire logic                     csr_wen,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [DUR_BITS-1:0]      csr_wdata
);

   localparam int OUT_W = ((PHASE_BITS + 3 + 7) / 8) * 8;
   localparam int CW    = (TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS;

   state_type state_ff, state_in;

   op_type                op_ff;
   logic [TIME_BITS-1:0]  now_ff;
   logic [TIME_BITS-1:0]  start_ff;
   logic [TIME_BITS-1:0]  pause_ff;
   logic                  running_ff;
   logic                  halted_ff;
   logic [DUR_BITS-1:0]   duration_ff;
   logic                  periodic_ff;
   logic                  pvalid_ff;
   logic                  rsp_valid_ff;
   logic [OUT_W-1:0]      rsp_data_ff;

   logic [TIME_BITS-1:0]  start_eff;
   logic [TIME_BITS-1:0]  elapsed;
   logic                  at_end;
   logic                  play_ok;
   logic                  go;
   logic                  div_start;
   logic                  out_load;
   logic [CW-1:0]         div_num;
   logic [PHASE_BITS-1:0] quotient;
   logic [PHASE_BITS-1:0] phase;
   div_status_type        div_status;

   always_comb begin
      start_eff = (start_ff == '0) ? now_ff : start_ff;
      elapsed   = now_ff - start_eff;
      at_end    = CW'(elapsed) >= CW'(duration_ff);
      play_ok   = running_ff && !halted_ff;
      go        = (op_ff == OP_PLAY) && play_ok && (!at_end || periodic_ff);
      div_num   = at_end ? '0 : CW'(elapsed);
      phase     = (pvalid_ff && (duration_ff != '0)) ? quotient : '0;
   end

   ppt_div #(
      .W  (CW),
      .QB (PHASE_BITS)
   ) u_div (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (CW'(duration_ff)),
      .quotient    (quotient),
      .status      (div_status)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) state_in = ST_EVAL;
         ST_EVAL: state_in = go ? ST_DIV : ST_DONE;
         ST_DIV:  if (div_status.done) state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_tready = !reset;
         ST_EVAL: div_start  = go;
         ST_DIV:  ;
         ST_DONE: out_load   = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         pause_ff     <= '0;
         running_ff   <= 1'b1;
         halted_ff    <= 1'b0;
         duration_ff  <= DUR_BITS'(1);
         periodic_ff  <= 1'b0;
         pvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wen) begin
            unique case (csr_addr)
               CSR_DURATION: duration_ff <= csr_wdata;
               CSR_PERIODIC: periodic_ff <= csr_wdata[0];
               default: ;
            endcase
         end
         if (state_ff == ST_EVAL) begin
            pvalid_ff <= go;
            unique case (op_ff)
               OP_PLAY: begin
                  if (play_ok) begin
                     start_ff <= (at_end && periodic_ff) ? now_ff : start_eff;
                     if (at_end && !periodic_ff) running_ff <= 1'b0;
                  end
               end
               OP_PAUSE: begin
                  if (!halted_ff) begin
                     halted_ff <= 1'b1;
                     pause_ff  <= now_ff;
                  end
               end
               OP_RESUME: begin
                  if (halted_ff) begin
                     if (start_ff != '0) start_ff <= start_ff + (now_ff - pause_ff);
                     halted_ff <= 1'b0;
                  end
               end
               OP_RESTART: begin
                  start_ff   <= '0;
                  pause_ff   <= '0;
                  running_ff <= 1'b1;
                  halted_ff  <= 1'b0;
               end
               default: ;
            endcase
         end
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         op_ff  <= op_type'(req_tdata[OP_BITS-1:0]);
         now_ff <= req_tdata[OP_BITS+TIME_BITS-1:OP_BITS];
      end
      if (out_load) begin
         rsp_data_ff <= OUT_W'({halted_ff, running_ff, pvalid_ff, phase});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_status.busy)
      else $error("input ready while divider busy");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider done outside divide state");

   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> (state_ff == ST_DIV) || (state_ff == ST_DONE))
      else $error("bad exit from divide state");

   a_invalid_phase_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[PHASE_BITS]) |-> (rsp_tdata[PHASE_BITS-1:0] == '0))
      else $error("nonzero phase without phase_valid");

endmodule

`default_nettype wire
